// ----- rtl/ppsm_pkg.sv -----
// Shared types and codes for the pinned page slot manager.
// No dependencies; every other file imports this package.
package ppsm_pkg;

   localparam int PAGE_W     = 28;
   localparam int TOKEN_W    = 7;
   localparam int STATUS_W   = 4;
   localparam int BYTES_W    = 13;
   localparam int FLEN_W     = 41;
   localparam int LIMIT_W    = 7;
   localparam int HOTCNT_W   = 3;
   localparam int PINS_W     = 16;
   localparam int CSR_IDX_W  = 4;

   localparam logic [PINS_W-1:0] PIN_MAX = '1;

   // slot phases
   localparam logic [1:0] PH_EMPTY   = 2'd0;
   localparam logic [1:0] PH_LOADING = 2'd1;
   localparam logic [1:0] PH_READY   = 2'd2;

   // request codes
   localparam logic [1:0] REQ_ACQUIRE  = 2'd0;
   localparam logic [1:0] REQ_RELEASE  = 2'd1;
   localparam logic [1:0] REQ_COMPLETE = 2'd2;
   localparam logic [1:0] REQ_CLEAR    = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STS_HIT_READY    = 4'd0;
   localparam logic [STATUS_W-1:0] STS_HIT_LOADING  = 4'd1;
   localparam logic [STATUS_W-1:0] STS_MISS_READ    = 4'd2;
   localparam logic [STATUS_W-1:0] STS_NO_CAPACITY  = 4'd3;
   localparam logic [STATUS_W-1:0] STS_OUT_OF_RANGE = 4'd4;
   localparam logic [STATUS_W-1:0] STS_NO_VICTIM    = 4'd5;
   localparam logic [STATUS_W-1:0] STS_RELEASED     = 4'd6;
   localparam logic [STATUS_W-1:0] STS_REL_IGNORED  = 4'd7;
   localparam logic [STATUS_W-1:0] STS_CPL_OK       = 4'd8;
   localparam logic [STATUS_W-1:0] STS_CPL_INVALID  = 4'd9;
   localparam logic [STATUS_W-1:0] STS_CLEARED      = 4'd10;
   localparam logic [STATUS_W-1:0] STS_CLR_REFUSED  = 4'd11;
   localparam logic [STATUS_W-1:0] STS_PIN_OVERFLOW = 4'd12;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FILE_LEN  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_COUNT = 4'd3;
   localparam int                   CSR_HOT_BASE  = 4;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [PAGE_W-1:0]  page;
      logic [TOKEN_W-1:0] token;
   } request_type;

   typedef struct packed {
      logic [TOKEN_W-1:0]  token_out;
      logic [STATUS_W-1:0] status;
      logic                page_ready;
      logic [PAGE_W-1:0]   read_page;
      logic [BYTES_W-1:0]  read_bytes;
   } response_type;

   typedef struct packed {
      logic [PINS_W-1:0] pins;
      logic [1:0]        phase;
      logic              referenced;
      logic              hot;
   } slot_state_type;

   typedef struct packed {
      logic page_we;
      logic state_we;
      logic clear_all;
   } slot_wr_type;

endpackage

// ----- rtl/ppsm_slot_store.sv -----
// Per-slot page tags and state words, one read and one write port.
// Depends on ppsm_pkg. State words read as zero until written or after clear.
module ppsm_slot_store #(
   parameter int SLOT_COUNT = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(SLOT_COUNT)-1:0]    rd_addr,
   input  logic [$clog2(SLOT_COUNT)-1:0]    wr_addr,
   input  ppsm_pkg::slot_wr_type            wr_ctl,
   input  logic [ppsm_pkg::PAGE_W-1:0]      wr_page,
   input  ppsm_pkg::slot_state_type         wr_state,
   output logic [ppsm_pkg::PAGE_W-1:0]      rd_page,
   output ppsm_pkg::slot_state_type         rd_state
);
   import ppsm_pkg::*;

   logic [PAGE_W-1:0]     page_mem [SLOT_COUNT];
   slot_state_type        state_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff;
   logic [PAGE_W-1:0]     rd_page_ff;
   slot_state_type        rd_state_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_ctl.page_we) begin
         page_mem[wr_addr] <= wr_page;
      end
      if (wr_ctl.state_we) begin
         state_mem[wr_addr] <= wr_state;
      end
      rd_page_ff  <= page_mem[rd_addr];
      rd_state_ff <= state_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr_ctl.clear_all) begin
            valid_ff <= '0;
         end else if (wr_ctl.state_we) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_page  = rd_page_ff;
   assign rd_state = rd_valid_ff ? rd_state_ff : '0;

endmodule

// ----- rtl/ppsm_rec_ram.sv -----
// Recency list storage: simple dual-port RAM with registered read.
// Imports ppsm_pkg but uses nothing from it; holds slot indexes.
module ppsm_rec_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import ppsm_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pinned_page_slot_manager.sv -----
// Pinned page slot manager: top level with the request sequencer.
// Depends on ppsm_pkg, ppsm_slot_store and ppsm_rec_ram.
//
// One request at a time: a transfer happens when start is high and busy is
// low; busy stays high until the result strobe, and the result sits on
// rsp_data for the single cycle rsp_strobe is high (it cannot be held off).
// All slot state lives in one single-port-read slot store that is walked
// one slot per clock, so the cost per request is set by that walk:
// release and completion read only the token's slot, clear and lookup
// walk the slots, an out-of-range acquire ends before the lookup, a hit on
// a ready, unpinned, non-hot slot also compacts the recency list, and a
// miss with no empty slot picks a victim (recency-list head or second-chance
// sweep) and pulls it out of the recency list before the fill. No clearing pass is
// needed after reset: per-slot valid bits make untouched slots read empty.
// Configuration writes land at once and must be issued while idle.
module pinned_page_slot_manager #(
   parameter int SLOT_COUNT  = 64,
   parameter int PAGE_BYTES  = 4096,
   parameter int HOT_ENTRIES = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  ppsm_pkg::request_type              req_data,
   output logic                               rsp_strobe,
   output ppsm_pkg::response_type             rsp_data,
   input  logic                               csr_we,
   input  logic [ppsm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppsm_pkg::FLEN_W-1:0]        csr_wdata
);
   import ppsm_pkg::*;

   localparam int AW        = $clog2(SLOT_COUNT);
   localparam int LW        = $clog2(SLOT_COUNT + 1);
   localparam int SW        = $clog2(2 * SLOT_COUNT);
   localparam int PBW       = $clog2(PAGE_BYTES + 1);
   localparam int PW        = PAGE_W + PBW;
   localparam int CW        = (PW > FLEN_W) ? PW : FLEN_W;
   localparam int HOT_SLOTS = (HOT_ENTRIES > 0) ? HOT_ENTRIES : 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_RANGE, ST_LOOK, ST_HIT, ST_MISS, ST_HEAD_RD, ST_HEAD,
      ST_SWEEP, ST_REMOVE, ST_FILL, ST_TOK_RD, ST_TOK, ST_CLR_SCAN
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // latched request
   logic [1:0]         typ_ff, typ_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [TOKEN_W-1:0] tok_ff, tok_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [BYTES_W-1:0] rbytes_ff, rbytes_in;

   // scan pipeline (issue counter, then check in the cycle after issue)
   logic [LW-1:0]      scan_ff, scan_in;
   logic [AW-1:0]      sw_iss_ff, sw_iss_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [AW-1:0]      chk_idx_ff, chk_idx_in;
   logic               found_free_ff, found_free_in;
   logic [AW-1:0]      free_idx_ff, free_idx_in;
   logic [AW-1:0]      victim_ff, victim_in;
   slot_state_type     hold_ff, hold_in;
   logic               busy_acc_ff, busy_acc_in;
   logic [SW-1:0]      step_ff, step_in;

   // recency compaction
   logic [LW-1:0]      rm_i_ff, rm_i_in;
   logic [LW-1:0]      rm_j_ff, rm_j_in;
   logic               rm_vld_ff, rm_vld_in;
   logic               fill_after_ff, fill_after_in;
   response_type       pend_ff, pend_in;

   // global counters
   logic [AW-1:0]      hand_ff, hand_in;
   logic [LW-1:0]      loading_ff, loading_in;
   logic [LW-1:0]      evict_ff, evict_in;
   logic [LW-1:0]      len_ff, len_in;

   // configuration
   logic [FLEN_W-1:0]   flen_ff, flen_in;
   logic                policy_ff, policy_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [HOTCNT_W-1:0] hotcnt_ff, hotcnt_in;
   logic [PAGE_W-1:0]   hot_ff [HOT_SLOTS];
   logic [PAGE_W-1:0]   hot_in [HOT_SLOTS];

   response_type        rsp_ff, rsp_in;
   logic                strobe_ff, strobe_in;

   // store ports
   logic [AW-1:0]       slot_raddr, slot_waddr;
   slot_wr_type         slot_ctl;
   logic [PAGE_W-1:0]   slot_wpage;
   slot_state_type      slot_wstate;
   logic [PAGE_W-1:0]   slot_rpage;
   slot_state_type      slot_rstate;
   logic                rec_we;
   logic [AW-1:0]       rec_waddr, rec_raddr;
   logic [AW-1:0]       rec_wdata, rec_rdata;

   ppsm_slot_store #(.SLOT_COUNT(SLOT_COUNT)) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (slot_raddr),
      .wr_addr  (slot_waddr),
      .wr_ctl   (slot_ctl),
      .wr_page  (slot_wpage),
      .wr_state (slot_wstate),
      .rd_page  (slot_rpage),
      .rd_state (slot_rstate)
   );

   ppsm_rec_ram #(.DEPTH(SLOT_COUNT), .WIDTH(AW)) u_rec (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      slot_state_type      st;
      response_type        r;
      logic                iss;
      logic                elig;
      logic                tok_ok;
      logic                is_hot;
      logic [AW-1:0]       tok_idx;
      logic [AW-1:0]       nxt;
      logic [CW-1:0]       rem;
      logic [HOTCNT_W-1:0] hot_n;
      logic [PINS_W-1:0]   pins_dec;

      state_in      = state_ff;
      typ_in        = typ_ff;
      page_in       = page_ff;
      tok_in        = tok_ff;
      prod_in       = prod_ff;
      rbytes_in     = rbytes_ff;
      scan_in       = scan_ff;
      sw_iss_in     = sw_iss_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      found_free_in = found_free_ff;
      free_idx_in   = free_idx_ff;
      victim_in     = victim_ff;
      hold_in       = hold_ff;
      busy_acc_in   = busy_acc_ff;
      step_in       = step_ff;
      rm_i_in       = rm_i_ff;
      rm_j_in       = rm_j_ff;
      rm_vld_in     = 1'b0;
      fill_after_in = fill_after_ff;
      pend_in       = pend_ff;
      hand_in       = hand_ff;
      loading_in    = loading_ff;
      evict_in      = evict_ff;
      len_in        = len_ff;
      flen_in       = flen_ff;
      policy_in     = policy_ff;
      limit_in      = limit_ff;
      hotcnt_in     = hotcnt_ff;
      hot_in        = hot_ff;
      rsp_in        = rsp_ff;
      strobe_in     = 1'b0;

      slot_raddr  = scan_ff[AW-1:0];
      slot_waddr  = victim_ff;
      slot_ctl    = '0;
      slot_wpage  = page_ff;
      slot_wstate = hold_ff;
      rec_we      = 1'b0;
      rec_waddr   = len_ff[AW-1:0];
      rec_wdata   = victim_ff;
      rec_raddr   = rm_i_ff[AW-1:0];

      st       = slot_rstate;
      r        = '0;
      iss      = 1'b0;
      elig     = 1'b0;
      rem      = CW'(flen_ff) - CW'(prod_ff);
      tok_ok   = (tok_ff != '0) && (32'(tok_ff) <= SLOT_COUNT);
      tok_idx  = AW'(32'(tok_ff) - 32'd1);
      nxt      = (chk_idx_ff == AW'(SLOT_COUNT - 1)) ? '0 : chk_idx_ff + 1'b1;
      pins_dec = st.pins - 1'b1;

      hot_n  = (32'(hotcnt_ff) > HOT_ENTRIES) ? HOTCNT_W'(HOT_ENTRIES) : hotcnt_ff;
      is_hot = 1'b0;
      for (int k = 0; k < HOT_SLOTS; k++) begin
         if (k < HOT_ENTRIES && 32'(k) < 32'(hot_n) && hot_ff[k] == page_ff) begin
            is_hot = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               typ_in  = req_data.req_type;
               page_in = req_data.page;
               tok_in  = req_data.token;
               scan_in = '0;
               busy_acc_in = 1'b0;
               case (req_data.req_type)
                  REQ_ACQUIRE: state_in = ST_MUL;
                  REQ_CLEAR:   state_in = ST_CLR_SCAN;
                  default:     state_in = ST_TOK_RD;
               endcase
            end
         end

         ST_MUL: begin
            prod_in  = PW'(page_ff) * PW'(PAGE_BYTES);
            state_in = ST_RANGE;
         end

         ST_RANGE: begin
            if (CW'(prod_ff) >= CW'(flen_ff)) begin
               r.status  = STS_OUT_OF_RANGE;
               rsp_in    = r;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               rbytes_in = (rem < CW'(PAGE_BYTES)) ? BYTES_W'(rem) : BYTES_W'(PAGE_BYTES);
               scan_in   = '0;
               found_free_in = 1'b0;
               state_in  = ST_LOOK;
            end
         end

         // tag lookup, also notes the lowest empty slot
         ST_LOOK: begin
            iss        = (32'(scan_ff) < SLOT_COUNT);
            chk_vld_in = iss;
            chk_idx_in = scan_ff[AW-1:0];
            if (iss) begin
               scan_in = scan_ff + 1'b1;
            end
            if (chk_vld_ff && st.phase == PH_EMPTY && !found_free_ff) begin
               found_free_in = 1'b1;
               free_idx_in   = chk_idx_ff;
            end
            if (chk_vld_ff && (st.phase == PH_LOADING || st.phase == PH_READY)
                && slot_rpage == page_ff) begin
               victim_in = chk_idx_ff;
               hold_in   = st;
               state_in  = ST_HIT;
            end else if (!chk_vld_ff && !iss) begin
               state_in = ST_MISS;
            end
         end

         ST_HIT: begin
            if (hold_ff.pins == PIN_MAX) begin
               r.status  = STS_PIN_OVERFLOW;
               rsp_in    = r;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               slot_wstate            = hold_ff;
               slot_wstate.pins       = hold_ff.pins + 1'b1;
               slot_wstate.referenced = 1'b1;
               slot_ctl.state_we      = 1'b1;
               r.token_out = TOKEN_W'(32'(victim_ff) + 1);
               if (hold_ff.phase == PH_READY) begin
                  r.status     = STS_HIT_READY;
                  r.page_ready = 1'b1;
               end else begin
                  r.status = STS_HIT_LOADING;
               end
               if (hold_ff.phase == PH_READY && hold_ff.pins == '0 && !hold_ff.hot) begin
                  // was evictable: drop it from the recency list first
                  if (evict_ff != '0) begin
                     evict_in = evict_ff - 1'b1;
                  end
                  pend_in       = r;
                  rm_i_in       = '0;
                  rm_j_in       = '0;
                  fill_after_in = 1'b0;
                  state_in      = ST_REMOVE;
               end else begin
                  rsp_in    = r;
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end

         ST_MISS: begin
            if (!(32'(loading_ff) < 32'(limit_ff)) || (!found_free_ff && evict_ff == '0)) begin
               r.status  = STS_NO_CAPACITY;
               rsp_in    = r;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (found_free_ff) begin
               victim_in = free_idx_ff;
               state_in  = ST_FILL;
            end else if (!policy_ff) begin
               if (len_ff == '0) begin
                  r.status  = STS_NO_VICTIM;
                  rsp_in    = r;
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_HEAD_RD;
               end
            end else begin
               sw_iss_in = hand_ff;
               step_in   = '0;
               state_in  = ST_SWEEP;
            end
         end

         ST_HEAD_RD: begin
            rec_raddr = '0;
            state_in  = ST_HEAD;
         end

         ST_HEAD: begin
            victim_in = rec_rdata;
            if (evict_ff != '0) begin
               evict_in = evict_ff - 1'b1;
            end
            rm_i_in       = '0;
            rm_j_in       = '0;
            fill_after_in = 1'b1;
            state_in      = ST_REMOVE;
         end

         // second-chance clock: the hand follows the checked slot
         ST_SWEEP: begin
            slot_raddr = sw_iss_ff;
            sw_iss_in  = (sw_iss_ff == AW'(SLOT_COUNT - 1)) ? '0 : sw_iss_ff + 1'b1;
            chk_vld_in = 1'b1;
            chk_idx_in = sw_iss_ff;
            if (chk_vld_ff) begin
               hand_in = nxt;
               step_in = step_ff + 1'b1;
               elig    = (st.phase == PH_READY) && (st.pins == '0) && !st.hot;
               if (elig && st.referenced) begin
                  slot_waddr             = chk_idx_ff;
                  slot_wstate            = st;
                  slot_wstate.referenced = 1'b0;
                  slot_ctl.state_we      = 1'b1;
               end
               if (elig && !st.referenced) begin
                  victim_in = chk_idx_ff;
                  if (evict_ff != '0) begin
                     evict_in = evict_ff - 1'b1;
                  end
                  rm_i_in       = '0;
                  rm_j_in       = '0;
                  fill_after_in = 1'b1;
                  state_in      = ST_REMOVE;
               end else if (step_ff == SW'(2 * SLOT_COUNT - 1)) begin
                  r.status  = STS_NO_VICTIM;
                  rsp_in    = r;
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end

         // compact the recency list, dropping the victim index
         ST_REMOVE: begin
            iss       = (rm_i_ff < len_ff);
            rm_vld_in = iss;
            if (iss) begin
               rm_i_in = rm_i_ff + 1'b1;
            end
            if (rm_vld_ff && rec_rdata != victim_ff) begin
               rec_we    = 1'b1;
               rec_waddr = rm_j_ff[AW-1:0];
               rec_wdata = rec_rdata;
               rm_j_in   = rm_j_ff + 1'b1;
            end
            if (!rm_vld_ff && !iss) begin
               len_in = rm_j_ff;
               if (fill_after_ff) begin
                  state_in = ST_FILL;
               end else begin
                  rsp_in    = pend_ff;
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end

         ST_FILL: begin
            slot_wstate.pins       = PINS_W'(1);
            slot_wstate.phase      = PH_LOADING;
            slot_wstate.referenced = 1'b1;
            slot_wstate.hot        = is_hot;
            slot_ctl.state_we      = 1'b1;
            slot_ctl.page_we       = 1'b1;
            loading_in   = loading_ff + 1'b1;
            r.token_out  = TOKEN_W'(32'(victim_ff) + 1);
            r.status     = STS_MISS_READ;
            r.read_page  = page_ff;
            r.read_bytes = rbytes_ff;
            rsp_in       = r;
            strobe_in    = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_TOK_RD: begin
            slot_raddr = tok_idx;
            state_in   = ST_TOK;
         end

         ST_TOK: begin
            slot_waddr  = tok_idx;
            slot_wstate = st;
            rec_wdata   = tok_idx;
            if (typ_ff == REQ_RELEASE) begin
               if (!tok_ok || st.pins == '0) begin
                  r.status = STS_REL_IGNORED;
               end else begin
                  slot_wstate.pins  = pins_dec;
                  slot_ctl.state_we = 1'b1;
                  if (pins_dec == '0 && st.phase == PH_READY && !st.hot) begin
                     evict_in = evict_ff + 1'b1;
                     if (32'(len_ff) < SLOT_COUNT) begin
                        rec_we = 1'b1;
                        len_in = len_ff + 1'b1;
                     end
                  end
                  r.status = STS_RELEASED;
               end
            end else begin
               if (!tok_ok || st.phase != PH_LOADING) begin
                  r.status = STS_CPL_INVALID;
               end else begin
                  slot_wstate.phase = PH_READY;
                  slot_ctl.state_we = 1'b1;
                  if (loading_ff != '0) begin
                     loading_in = loading_ff - 1'b1;
                  end
                  if (st.pins == '0 && !st.hot) begin
                     evict_in = evict_ff + 1'b1;
                     if (32'(len_ff) < SLOT_COUNT) begin
                        rec_we = 1'b1;
                        len_in = len_ff + 1'b1;
                     end
                  end
                  r.status = STS_CPL_OK;
               end
            end
            rsp_in    = r;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end

         // clear: refuse if any slot is pinned or loading
         ST_CLR_SCAN: begin
            iss        = (32'(scan_ff) < SLOT_COUNT);
            chk_vld_in = iss;
            if (iss) begin
               scan_in = scan_ff + 1'b1;
            end
            if (chk_vld_ff && (st.pins != '0 || st.phase == PH_LOADING)) begin
               busy_acc_in = 1'b1;
            end
            if (!chk_vld_ff && !iss) begin
               if (loading_ff != '0 || busy_acc_ff) begin
                  r.status = STS_CLR_REFUSED;
               end else begin
                  slot_ctl.clear_all = 1'b1;
                  len_in   = '0;
                  evict_in = '0;
                  hand_in  = '0;
                  r.status = STS_CLEARED;
               end
               rsp_in    = r;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_FILE_LEN:  flen_in   = csr_wdata;
            CSR_POLICY:    policy_in = csr_wdata[0];
            CSR_LIMIT:     limit_in  = csr_wdata[LIMIT_W-1:0];
            CSR_HOT_COUNT: hotcnt_in = csr_wdata[HOTCNT_W-1:0];
            default: begin
               for (int k = 0; k < HOT_SLOTS; k++) begin
                  if (k < HOT_ENTRIES && csr_index == CSR_IDX_W'(CSR_HOT_BASE + k)) begin
                     hot_in[k] = csr_wdata[PAGE_W-1:0];
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         chk_vld_ff <= 1'b0;
         rm_vld_ff  <= 1'b0;
         strobe_ff  <= 1'b0;
         hand_ff    <= '0;
         loading_ff <= '0;
         evict_ff   <= '0;
         len_ff     <= '0;
         flen_ff    <= FLEN_W'(1);
         policy_ff  <= 1'b0;
         limit_ff   <= LIMIT_W'(1);
         hotcnt_ff  <= '0;
         for (int k = 0; k < HOT_SLOTS; k++) begin
            hot_ff[k] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         rm_vld_ff  <= rm_vld_in;
         strobe_ff  <= strobe_in;
         hand_ff    <= hand_in;
         loading_ff <= loading_in;
         evict_ff   <= evict_in;
         len_ff     <= len_in;
         flen_ff    <= flen_in;
         policy_ff  <= policy_in;
         limit_ff   <= limit_in;
         hotcnt_ff  <= hotcnt_in;
         hot_ff     <= hot_in;
      end
      typ_ff        <= typ_in;
      page_ff       <= page_in;
      tok_ff        <= tok_in;
      prod_ff       <= prod_in;
      rbytes_ff     <= rbytes_in;
      scan_ff       <= scan_in;
      sw_iss_ff     <= sw_iss_in;
      chk_idx_ff    <= chk_idx_in;
      found_free_ff <= found_free_in;
      free_idx_ff   <= free_idx_in;
      victim_ff     <= victim_in;
      hold_ff       <= hold_in;
      busy_acc_ff   <= busy_acc_in;
      step_ff       <= step_in;
      rm_i_ff       <= rm_i_in;
      rm_j_ff       <= rm_j_in;
      fill_after_ff <= fill_after_in;
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
   end

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while sequencer still busy");

   a_loading_bound: assert property (@(posedge clock) disable iff (reset)
      32'(loading_ff) <= SLOT_COUNT)
      else $error("loading count beyond slot count");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      32'(len_ff) <= SLOT_COUNT)
      else $error("recency list longer than slot count");

   a_miss_token: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == STS_MISS_READ |-> rsp_data.token_out != '0)
      else $error("read issued without a slot token");
`endif

endmodule
